FILE: hdl/bmd_pkg.sv
// Shared types, constants and rounding helpers for the Bayer MHC demosaicer.
// No dependencies; every other file of the block but bmd_ram imports this package.
package bmd_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int SUM_W      = 16;
  localparam int FIFO_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(424);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(636);

  // Thirteen kernel taps around the center plus the Bayer phase of the pixel
  typedef struct packed {
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] w1;
    logic [PIX_W-1:0] e1;
    logic [PIX_W-1:0] n1;
    logic [PIX_W-1:0] s1;
    logic [PIX_W-1:0] w2;
    logic [PIX_W-1:0] e2;
    logic [PIX_W-1:0] n2;
    logic [PIX_W-1:0] s2;
    logic [PIX_W-1:0] nw;
    logic [PIX_W-1:0] ne;
    logic [PIX_W-1:0] sw;
    logic [PIX_W-1:0] se;
    logic             row_odd;
    logic             col_odd;
  } bmd_taps_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             eol;
    logic             eof;
  } bmd_pixel_t;

  // Divide a 16x sum by 16, truncating, and clamp to the pixel range
  function automatic logic [PIX_W-1:0] trunc16(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s >>> 4;
    if (s <= 0) return '0;
    if (q > 255) return 8'hFF;
    return q[PIX_W-1:0];
  endfunction

  // Divide a 16x sum by 16, rounding half up on positive values, and clamp
  function automatic logic [PIX_W-1:0] round16(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = (s + SUM_W'(8)) >>> 4;
    if (s <= 0) return '0;
    if (q > 255) return 8'hFF;
    return q[PIX_W-1:0];
  endfunction

endpackage

FILE: hdl/bmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bmd_kernel.sv
// MHC kernel arithmetic: turns thirteen mirrored taps into one RGB pixel.
// Depends on bmd_pkg for the tap struct and the rounding helpers.
module bmd_kernel (
  input  bmd_pkg::bmd_taps_t taps_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);
  import bmd_pkg::*;

  logic signed [SUM_W-1:0] ctr, hn, vn, hf, vf, diag, n4, far;
  logic signed [SUM_W-1:0] g_sum, x_sum, h_sum, v_sum;

  // Neighbor sums at unit weight
  always_comb begin
    ctr  = SUM_W'(taps_i.ctr);
    hn   = SUM_W'(taps_i.w1) + SUM_W'(taps_i.e1);
    vn   = SUM_W'(taps_i.n1) + SUM_W'(taps_i.s1);
    hf   = SUM_W'(taps_i.w2) + SUM_W'(taps_i.e2);
    vf   = SUM_W'(taps_i.n2) + SUM_W'(taps_i.s2);
    diag = SUM_W'(taps_i.nw) + SUM_W'(taps_i.ne) + SUM_W'(taps_i.sw) + SUM_W'(taps_i.se);
    n4   = hn + vn;
    far  = hf + vf;
  end

  // Kernels at sixteen times pixel scale
  always_comb begin
    g_sum = (ctr <<< 3) + (n4 <<< 2) - (far <<< 1);
    x_sum = (ctr <<< 3) + (ctr <<< 2) + (diag <<< 2) - (far <<< 1) - far;
    h_sum = (ctr <<< 3) + (ctr <<< 1) + (hn <<< 3) - (diag <<< 1) - (hf <<< 1) + vf;
    v_sum = (ctr <<< 3) + (ctr <<< 1) + (vn <<< 3) - (diag <<< 1) - (vf <<< 1) + hf;
  end

  // Select per Bayer phase
  always_comb begin
    case ({taps_i.row_odd, taps_i.col_odd})
      2'b00: begin
        red_o   = taps_i.ctr;
        green_o = trunc16(g_sum);
        blue_o  = round16(x_sum);
      end
      2'b01: begin
        red_o   = round16(h_sum);
        green_o = taps_i.ctr;
        blue_o  = round16(v_sum);
      end
      2'b10: begin
        red_o   = round16(v_sum);
        green_o = taps_i.ctr;
        blue_o  = round16(h_sum);
      end
      default: begin
        red_o   = round16(x_sum);
        green_o = trunc16(g_sum);
        blue_o  = taps_i.ctr;
      end
    endcase
  end

endmodule

FILE: hdl/bmd_out_fifo.sv
// Output queue that decouples the fixed-latency pipeline from the consumer.
// Depends on bmd_pkg for the pixel struct and the queue depth.
module bmd_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmd_pkg::bmd_pixel_t data_i,
  input  logic                pop_i,
  output bmd_pkg::bmd_pixel_t data_o,
  output logic                valid_o,
  output logic [$clog2(bmd_pkg::FIFO_DEPTH):0] count_o
);
  import bmd_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  bmd_pixel_t      entry_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q, count_d;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Store pushed pixels
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_comb begin
    count_d = count_q;
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  assign data_o  = entry_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

FILE: hdl/bayer_mhc_demosaic.sv
// Streaming Malvar-He-Cutler demosaicer for 8-bit RGGB Bayer samples.
// Depends on bmd_pkg, bmd_ram, bmd_kernel and bmd_out_fifo.

// Takes one Bayer sample per cycle while in_ready_o is high, in raster order (red
// at even row and even column), and gives the RGB pixel two rows and two columns
// behind it, with mirrored borders. A frame needs frame_width*frame_height samples
// followed by 2*frame_width+2 drain items; the first 2*frame_width+2 items of a
// frame give no pixel. Sustained rate is one item per clock while in_ready_o is
// high: the column line store is one RAM word per column, read on acceptance and
// written back in the following cycle, so a new column can enter every cycle. The
// pixel of an accepted item passes the s1, s2 and s3 registers into an eight-entry
// output queue and then shows valid at the output; the queue lets input continue
// while pixels wait. Writing a size register restarts the frame.
module bayer_mhc_demosaic #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bmd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bmd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    sample_i,
  input  logic                          drain_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic                          end_of_line_o,
  output logic                          end_of_frame_o
);
  import bmd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWW = $clog2(MAX_WIDTH) + 1;
  localparam int EHW = $clog2(MAX_HEIGHT) + 1;
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int IRW = $clog2(MAX_HEIGHT) + 2;
  localparam int QCW = $clog2(FIFO_DEPTH) + 1;

  // Configuration and effective frame size
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [EWW-1:0]   eff_w;
  logic [EHW-1:0]   eff_h;

  always_comb begin
    if (frame_width_q < CFG_W'(2)) eff_w = EWW'(2);
    else if (int'(frame_width_q) > MAX_WIDTH) eff_w = EWW'(MAX_WIDTH);
    else eff_w = EWW'(frame_width_q);
    if (frame_height_q < CFG_W'(2)) eff_h = EHW'(2);
    else if (int'(frame_height_q) > MAX_HEIGHT) eff_h = EHW'(MAX_HEIGHT);
    else eff_h = EHW'(frame_height_q);
  end

  logic cfg_fire, cfg_hit;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_fire && (cfg_index_i == REG_FRAME_WIDTH ||
                                    cfg_index_i == REG_FRAME_HEIGHT);

  // Position counters
  logic [CW-1:0]  in_col_q, out_col_q;
  logic [IRW-1:0] in_row_q;
  logic [ORW-1:0] out_row_q;
  logic           in_fire, has_out, eol, eof;

  assign in_fire = in_valid_i && in_ready_o;
  assign has_out = (in_row_q >= IRW'(3)) ||
                   ((in_row_q == IRW'(2)) && (in_col_q >= CW'(2)));
  assign eol     = (EWW'(out_col_q) + EWW'(1)) >= eff_w;
  assign eof     = eol && ((EHW'(out_row_q) + EHW'(1)) >= eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == REG_FRAME_WIDTH) frame_width_q <= cfg_data_i;
      else frame_height_q <= cfg_data_i;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (in_fire) begin
      if (has_out && eof) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if ((EWW'(in_col_q) + EWW'(1)) >= eff_w) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
        if (has_out) begin
          if (eol) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 1'b1;
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
        end
      end
    end
  end

  // Mirrored window row and column selects for the next output pixel
  logic [2:0] rsel [5];
  logic [2:0] csel [5];

  always_comb begin
    int m, rr, cc, hh, ww;
    rr = int'(out_row_q);
    cc = int'(out_col_q);
    hh = int'(eff_h);
    ww = int'(eff_w);
    for (int k = 0; k < 5; k++) begin
      m = rr + k - 2;
      if (m < 0) m = -1 - m;
      else if (m >= hh) m = 2 * hh - 1 - m;
      rsel[k] = 3'(m - rr + 2);
      m = cc + k - 2;
      if (m < 0) m = -1 - m;
      else if (m >= ww) m = 2 * ww - 1 - m;
      csel[k] = 3'(m - cc + 2);
    end
  end

  // Line store: one word of four rows per column
  logic              s1_valid_q, s1_out_q, s1_eol_q, s1_eof_q, s1_rodd_q, s1_codd_q;
  logic [CW-1:0]     s1_col_q;
  logic [1:0]        s1_lane_q;
  logic [7:0]        s1_v_q;
  logic [2:0]        s1_rsel_q [5];
  logic [2:0]        s1_csel_q [5];
  logic [4*PIX_W-1:0] ram_rdata, ram_wdata;

  bmd_ram #(
    .WIDTH(4 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(ram_wdata),
    .raddr_i(in_col_q),
    .rdata_o(ram_rdata)
  );

  // Replace the oldest row of the column with the new sample
  always_comb begin
    ram_wdata = ram_rdata;
    ram_wdata[s1_lane_q*PIX_W +: PIX_W] = s1_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q  <= in_col_q;
      s1_lane_q <= in_row_q[1:0];
      s1_v_q    <= drain_i ? 8'h00 : sample_i;
      s1_out_q  <= has_out;
      s1_eol_q  <= eol;
      s1_eof_q  <= eof;
      s1_rodd_q <= out_row_q[0];
      s1_codd_q <= out_col_q[0];
      s1_rsel_q <= rsel;
      s1_csel_q <= csel;
    end
  end

  // Shift the 5x5 window left and load the new column
  logic [7:0] win_q [5][5];
  logic [7:0] newcol [5];

  always_comb begin
    logic [1:0] ln;
    for (int k = 0; k < 4; k++) begin
      ln = s1_lane_q + 2'(k);
      newcol[k] = ram_rdata[ln*PIX_W +: PIX_W];
    end
    newcol[4] = s1_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) win_q[i][j] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) win_q[i][j] <= win_q[i][j+1];
        win_q[i][4] <= newcol[i];
      end
    end
  end

  // Stage two: pick mirrored taps from the updated window
  logic       s2_valid_q, s2_eol_q, s2_eof_q, s2_rodd_q, s2_codd_q;
  logic [2:0] s2_rsel_q [5];
  logic [2:0] s2_csel_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_eol_q  <= s1_eol_q;
    s2_eof_q  <= s1_eof_q;
    s2_rodd_q <= s1_rodd_q;
    s2_codd_q <= s1_codd_q;
    s2_rsel_q <= s1_rsel_q;
    s2_csel_q <= s1_csel_q;
  end

  bmd_taps_t taps_d, s3_taps_q;
  logic      s3_valid_q, s3_eol_q, s3_eof_q;

  always_comb begin
    taps_d.ctr     = win_q[s2_rsel_q[2]][s2_csel_q[2]];
    taps_d.w1      = win_q[s2_rsel_q[2]][s2_csel_q[1]];
    taps_d.e1      = win_q[s2_rsel_q[2]][s2_csel_q[3]];
    taps_d.n1      = win_q[s2_rsel_q[1]][s2_csel_q[2]];
    taps_d.s1      = win_q[s2_rsel_q[3]][s2_csel_q[2]];
    taps_d.w2      = win_q[s2_rsel_q[2]][s2_csel_q[0]];
    taps_d.e2      = win_q[s2_rsel_q[2]][s2_csel_q[4]];
    taps_d.n2      = win_q[s2_rsel_q[0]][s2_csel_q[2]];
    taps_d.s2      = win_q[s2_rsel_q[4]][s2_csel_q[2]];
    taps_d.nw      = win_q[s2_rsel_q[1]][s2_csel_q[1]];
    taps_d.ne      = win_q[s2_rsel_q[1]][s2_csel_q[3]];
    taps_d.sw      = win_q[s2_rsel_q[3]][s2_csel_q[1]];
    taps_d.se      = win_q[s2_rsel_q[3]][s2_csel_q[3]];
    taps_d.row_odd = s2_rodd_q;
    taps_d.col_odd = s2_codd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_taps_q <= taps_d;
    s3_eol_q  <= s2_eol_q;
    s3_eof_q  <= s2_eof_q;
  end

  // Stage three: kernel arithmetic into the output queue
  bmd_pixel_t pix_in, pix_out;
  logic [QCW-1:0] q_count;

  bmd_kernel u_kernel (
    .taps_i (s3_taps_q),
    .red_o  (pix_in.red),
    .green_o(pix_in.green),
    .blue_o (pix_in.blue)
  );

  assign pix_in.eol = s3_eol_q;
  assign pix_in.eof = s3_eof_q;

  bmd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s3_valid_q),
    .data_i (pix_in),
    .pop_i  (out_ready_i),
    .data_o (pix_out),
    .valid_o(out_valid_o),
    .count_o(q_count)
  );

  // Accept only while every pixel in flight still has a queue slot
  logic [QCW:0] occupancy;
  assign occupancy  = (QCW+1)'(q_count) + (QCW+1)'(s1_valid_q) +
                      (QCW+1)'(s2_valid_q) + (QCW+1)'(s3_valid_q);
  assign in_ready_o = occupancy < (QCW+1)'(FIFO_DEPTH);

  assign red_o          = pix_out.red;
  assign green_o        = pix_out.green;
  assign blue_o         = pix_out.blue;
  assign end_of_line_o  = pix_out.eol;
  assign end_of_frame_o = pix_out.eof;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the Bayer MHC demosaicer: streams RGGB frames and
// checks each RGB pixel against a behavioral predictor. Depends on bmd_pkg and bayer_mhc_demosaic.
`timescale 1ns / 100ps

module tb;
  import bmd_pkg::*;

  localparam int MAXW = 4096;
  localparam int MAXH = 4096;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] sample_i = '0;
  logic drain_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  logic [7:0] red_o, green_o, blue_o;
  logic end_of_line_o, end_of_frame_o;

  bayer_mhc_demosaic i_dut (.*);

  // Predictor state
  logic [7:0] line_mem [4*MAXW];
  logic [7:0] win [5][5];
  int in_col, in_row, out_col, out_row;
  logic [CFG_W-1:0] width_reg, height_reg;
  bmd_pixel_t pixel_q[$];

  int errors = 0;
  int pixels_checked = 0;
  int items_sent = 0;
  int frames_sent = 0;
  bit quiet = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("%0t: timeout, %0d pixels still expected", $realtime, pixel_q.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int eff_size(logic [CFG_W-1:0] v, int max_v);
    if (v < 2) return 2;
    if (v > max_v) return max_v;
    return int'(v);
  endfunction

  function automatic int mirror(int v, int n);
    if (v < 0) return -1 - v;
    if (v >= n) return 2 * n - 1 - v;
    return v;
  endfunction

  function automatic int tap(int r, int c, int dy, int dx, int w, int h);
    int i, j;
    i = mirror(r + dy, h) - r + 2;
    j = mirror(c + dx, w) - c + 2;
    if (i < 0 || i > 4 || j < 0 || j > 4) return 0;
    return int'(win[i][j]);
  endfunction

  function automatic logic [7:0] div16(int s, bit round_it);
    int q;
    if (s <= 0) return 8'd0;
    q = round_it ? (s + 8) >>> 4 : s >>> 4;
    return q > 255 ? 8'hFF : q[7:0];
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  // Advance the demosaic state by one accepted item; queue the pixel it yields
  function automatic void demosaic_step(logic [7:0] s, logic d);
    int w, h, col, pos, r, c, ctr, hn, vn, hf, vf, diag, n4, far;
    logic [7:0] v;
    logic [7:0] newcol [5];
    bmd_pixel_t px;
    w = eff_size(width_reg, MAXW);
    h = eff_size(height_reg, MAXH);
    v = d ? 8'd0 : s;
    col = in_col < MAXW ? in_col : MAXW - 1;
    pos = in_row * w + in_col;
    for (int k = 0; k < 4; k++) newcol[k] = line_mem[((in_row + k) & 3) * MAXW + col];
    newcol[4] = v;
    line_mem[(in_row & 3) * MAXW + col] = v;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
      win[i][4] = newcol[i];
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < 2 * w + 2) return;
    r = out_row; c = out_col;
    ctr = tap(r, c, 0, 0, w, h);
    hn = tap(r, c, 0, -1, w, h) + tap(r, c, 0, 1, w, h);
    vn = tap(r, c, -1, 0, w, h) + tap(r, c, 1, 0, w, h);
    hf = tap(r, c, 0, -2, w, h) + tap(r, c, 0, 2, w, h);
    vf = tap(r, c, -2, 0, w, h) + tap(r, c, 2, 0, w, h);
    diag = tap(r, c, -1, -1, w, h) + tap(r, c, -1, 1, w, h)
         + tap(r, c, 1, -1, w, h) + tap(r, c, 1, 1, w, h);
    n4 = hn + vn;
    far = hf + vf;
    if (!r[0] && !c[0]) begin
      px.red = ctr[7:0];
      px.green = div16(8 * ctr + 4 * n4 - 2 * far, 1'b0);
      px.blue = div16(12 * ctr + 4 * diag - 3 * far, 1'b1);
    end else if (!r[0]) begin
      px.red = div16(10 * ctr + 8 * hn - 2 * diag - 2 * hf + vf, 1'b1);
      px.green = ctr[7:0];
      px.blue = div16(10 * ctr + 8 * vn - 2 * diag - 2 * vf + hf, 1'b1);
    end else if (!c[0]) begin
      px.red = div16(10 * ctr + 8 * vn - 2 * diag - 2 * vf + hf, 1'b1);
      px.green = ctr[7:0];
      px.blue = div16(10 * ctr + 8 * hn - 2 * diag - 2 * hf + vf, 1'b1);
    end else begin
      px.red = div16(12 * ctr + 4 * diag - 3 * far, 1'b1);
      px.green = div16(8 * ctr + 4 * n4 - 2 * far, 1'b0);
      px.blue = ctr[7:0];
    end
    px.eol = (out_col + 1 >= w);
    px.eof = px.eol && (out_row + 1 >= h);
    pixel_q.push_back(px);
    if (px.eof) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // Check each pixel transaction and draw the next output stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    bmd_pixel_t exp_px;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        pixels_checked++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                   red_o, green_o, blue_o);
        end else begin
          exp_px = pixel_q.pop_front();
          if ({red_o, green_o, blue_o, end_of_line_o, end_of_frame_o} !== exp_px) begin
            errors++;
            $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d eol=%0b eof=%0b",
                     $realtime, exp_px.red, exp_px.green, exp_px.blue, exp_px.eol,
                     exp_px.eof);
            $display("%0t:                actual r=%0d g=%0d b=%0d eol=%0b eof=%0b",
                     $realtime, red_o, green_o, blue_o, end_of_line_o, end_of_frame_o);
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Send one item; called at a rising edge, returns at its acceptance edge
  task automatic send_item(logic [7:0] s, logic d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    drain_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    demosaic_step(s, d);
    items_sent++;
  endtask

  // Hold until no pixel is pending and the pipeline has drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    if (idx == REG_FRAME_HEIGHT) height_reg = val;
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) restart_frame();
  endtask

  // Stream a frame: pattern 0 random, 1 full-scale checkerboard, 2 random with
  // drains inside the frame and samples in the flush region
  task automatic send_frame(int pattern, int cut = -1);
    int w, h, n;
    logic [7:0] s;
    logic d;
    w = eff_size(width_reg, MAXW);
    h = eff_size(height_reg, MAXH);
    n = w * h + 2 * w + 2;
    if (cut >= 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) begin
      s = 8'($urandom_range(0, 255));
      d = 1'b0;
      if (pattern == 1) s = (((i / w) + (i % w)) & 1) ? 8'hFF : 8'h00;
      if (i >= w * h) d = !(pattern == 2 && $urandom_range(0, 2) == 0);
      else if (pattern == 2) d = ($urandom_range(0, 5) == 0);
      send_item(s, d);
    end
    frames_sent++;
  endtask

  task automatic test_saturation();
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_frame(1);
  endtask

  task automatic test_drain_and_flush();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    send_frame(2);
    send_frame(2);
  endtask

  task automatic test_size_clamp();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    send_frame(0);
    write_reg(REG_UNUSED, 13'h1FFF);
    send_frame(0);
  endtask

  // Tall frames: run the top rows of each, then restart with a size write
  task automatic test_large_sizes();
    quiet = 1'b1;
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_frame(0, 60);
    write_reg(REG_FRAME_HEIGHT, 13'd4096);
    send_frame(1, 60);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    quiet = 1'b0;
  endtask

  task automatic test_pause_mid_frame();
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    send_frame(0, 30);
    wait_idle();
    for (int i = 0; i < 6 * 4 + 14 - 30; i++) begin
      send_item(8'($urandom_range(0, 255)), i >= 24 - 30);
    end
  endtask

  task automatic test_random_frames();
    int start, pick, n;
    start = items_sent;
    while (items_sent - start < 470) begin
      pick = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 4) == 0);
      if (pick == 0) write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, 1)));
      else if (pick < 4) write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(2, 10)));
      if (pick == 9) write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 1)));
      else if (pick > 5) write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(2, 6)));
      if ($urandom_range(0, 7) == 0) begin
        // broken frame, cut short and restarted by a register write
        n = $urandom_range(1, 40);
        send_frame(0, n);
        write_reg(REG_FRAME_HEIGHT, height_reg);
      end else begin
        send_frame($urandom_range(0, 3) == 0 ? 2 : 0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    restart_frame();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_saturation();
    test_drain_and_flush();
    test_size_clamp();
    test_pause_mid_frame();
    test_large_sizes();
    test_random_frames();
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items in %0d frames, %0d pixels checked, %0d errors",
             items_sent, frames_sent, pixels_checked, errors);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
